### sv/rils_pkg.sv
package rils_pkg;

    localparam int NUM_LEDS    = 8;
    localparam int LED_W       = 3;
    localparam int MASK_W      = 8;
    localparam int PERIOD_W    = 16;
    localparam int HUE_W       = 11;
    localparam int DUTY_W      = 10;
    localparam int COLOR_W     = 8;
    localparam int RGB_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [11:0] HUE_WHEEL     = 12'd1536;
    localparam logic [11:0] HUE_WHEEL_X2  = 12'd3072;
    localparam logic [9:0]  DUTY_MAX      = 10'd1000;
    localparam logic [7:0]  OFFSET_MAX    = 8'd255;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;
    localparam logic [HUE_W-1:0]    STEP_RESET   = 11'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP      = 1'd1;

    // slot colour codes
    localparam logic [RGB_W-1:0] CLR_RED   = 2'd0;
    localparam logic [RGB_W-1:0] CLR_GREEN = 2'd1;
    localparam logic [RGB_W-1:0] CLR_BLUE  = 2'd2;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LED_W-1:0] anim;
        logic [LED_W-1:0] slot;
        logic [RGB_W-1:0] rgb;
    } t_update;

endpackage

### sv/rils_in_if.sv
interface rils_in_if;
    logic                            valid;
    logic                            ready;
    logic [rils_pkg::LED_W-1:0]      slot;
    logic [rils_pkg::COLOR_W-1:0]    slot_code;

    modport source (output valid, output slot, output slot_code, input ready);
    modport sink (input valid, input slot, input slot_code, output ready);
endinterface

### sv/rils_out_if.sv
interface rils_out_if;
    logic                            valid;
    logic                            ready;
    logic [rils_pkg::LED_W-1:0]      anim_index;
    logic [rils_pkg::DUTY_W-1:0]     red_duty;
    logic [rils_pkg::DUTY_W-1:0]     green_duty;
    logic [rils_pkg::DUTY_W-1:0]     blue_duty;
    logic [rils_pkg::LED_W-1:0]      slot_index;
    logic [rils_pkg::RGB_W-1:0]      slot_rgb;
    logic [rils_pkg::MASK_W-1:0]     off_mask;

    modport source (
        output valid, output anim_index, output red_duty, output green_duty,
        output blue_duty, output slot_index, output slot_rgb, output off_mask,
        input ready
    );
    modport sink (
        input valid, input anim_index, input red_duty, input green_duty,
        input blue_duty, input slot_index, input slot_rgb, input off_mask,
        output ready
    );
endinterface

### sv/rils_update.sv
module rils_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rils_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rils_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_tick,
    input  logic                              i_take,
    input  logic [rils_pkg::LED_W-1:0]        i_slot,
    input  logic [rils_pkg::COLOR_W-1:0]      i_slot_code,
    output logic                              o_upd_valid,
    output rils_pkg::t_update                 o_upd
);

    logic [rils_pkg::PERIOD_W-1:0] r_period;
    logic [rils_pkg::HUE_W-1:0]    r_step;
    logic [rils_pkg::PERIOD_W-1:0] r_tick_count;
    logic [rils_pkg::HUE_W-1:0]    r_hue;
    logic [rils_pkg::LED_W-1:0]    r_anim;
    logic                          r_upd_valid;
    rils_pkg::t_update             r_upd;

    logic [rils_pkg::PERIOD_W:0]   count;
    logic                          do_update;
    logic [11:0]                   hue_sum;
    logic [rils_pkg::HUE_W-1:0]    n_hue;
    logic [rils_pkg::LED_W-1:0]    anim_1;
    logic [rils_pkg::LED_W-1:0]    n_anim;
    logic [rils_pkg::RGB_W-1:0]    rgb;

    function automatic logic [rils_pkg::LED_W-1:0] next_led(
        input logic [rils_pkg::LED_W-1:0] pos
    );
        if ({1'b0, pos} == 4'(rils_pkg::NUM_LEDS - 1)) begin
            return '0;
        end
        return pos + 1'b1;
    endfunction

    assign count     = {1'b0, r_tick_count} + 1'b1;
    // a period of zero still fires on every tick
    assign do_update = count >= {1'b0, r_period};
    assign hue_sum   = {1'b0, r_hue} + {1'b0, r_step};

    always_comb begin
        if (hue_sum >= rils_pkg::HUE_WHEEL_X2) begin
            n_hue = rils_pkg::HUE_W'(hue_sum - rils_pkg::HUE_WHEEL_X2);
        end else if (hue_sum >= rils_pkg::HUE_WHEEL) begin
            n_hue = rils_pkg::HUE_W'(hue_sum - rils_pkg::HUE_WHEEL);
        end else begin
            n_hue = hue_sum[rils_pkg::HUE_W-1:0];
        end
    end

    // skip over the slot led
    assign anim_1 = next_led(r_anim);
    assign n_anim = (anim_1 == i_slot) ? next_led(anim_1) : anim_1;

    always_comb begin
        case (i_slot_code)
            rils_pkg::COLOR_W'(rils_pkg::CLR_RED):  rgb = rils_pkg::CLR_RED;
            rils_pkg::COLOR_W'(rils_pkg::CLR_BLUE): rgb = rils_pkg::CLR_BLUE;
            default:                                rgb = rils_pkg::CLR_GREEN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= rils_pkg::PERIOD_RESET;
            r_step       <= rils_pkg::STEP_RESET;
            r_tick_count <= '0;
            r_hue        <= '0;
            r_anim       <= '0;
            r_upd_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rils_pkg::CFG_UPDATE_PERIOD: r_period <= i_cfg_data;
                    default: r_step <= i_cfg_data[rils_pkg::HUE_W-1:0];
                endcase
            end
            if (i_tick) begin
                r_upd_valid <= do_update;
                if (do_update) begin
                    r_tick_count <= '0;
                    r_hue        <= n_hue;
                    r_anim       <= n_anim;
                end else begin
                    r_tick_count <= count[rils_pkg::PERIOD_W-1:0];
                end
            end else if (i_take) begin
                r_upd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_upd.hue  <= n_hue;
            r_upd.anim <= n_anim;
            r_upd.slot <= i_slot;
            r_upd.rgb  <= rgb;
        end
    end

    assign o_upd_valid = r_upd_valid;
    assign o_upd       = r_upd;

endmodule

### sv/rils_color.sv
module rils_color (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_upd_valid,
    input  rils_pkg::t_update  i_upd,
    output logic               o_take,
    rils_out_if.source         o_out
);

    logic [7:0]                  offset;
    logic [2:0]                  sector;
    logic [17:0]                 scaled;
    logic [25:0]                 recip;
    logic [9:0]                  q_est;
    logic [17:0]                 rem;
    logic [9:0]                  ramp;
    logic [9:0]                  ramp_inv;
    logic [rils_pkg::DUTY_W-1:0] red;
    logic [rils_pkg::DUTY_W-1:0] green;
    logic [rils_pkg::DUTY_W-1:0] blue;
    logic [rils_pkg::MASK_W-1:0] mask;
    logic                        r_valid;

    assign sector = i_upd.hue[10:8];
    assign offset = i_upd.hue[7:0];

    // offset*1000/255: estimate via 257/65536, then one correction step
    assign scaled = 18'(offset) * 18'd1000;
    assign recip  = 26'(offset) * 26'd257000;
    assign q_est  = recip[25:16];
    assign rem    = scaled - ((18'(q_est) << 8) - 18'(q_est));
    assign ramp   = (rem >= 18'(rils_pkg::OFFSET_MAX)) ? q_est + 1'b1 : q_est;
    assign ramp_inv = rils_pkg::DUTY_MAX - ramp;

    always_comb begin
        case (sector)
            3'd0: begin
                red = '0; green = ramp_inv; blue = rils_pkg::DUTY_MAX;
            end
            3'd1: begin
                red = ramp; green = '0; blue = rils_pkg::DUTY_MAX;
            end
            3'd2: begin
                red = rils_pkg::DUTY_MAX; green = '0; blue = ramp_inv;
            end
            3'd3: begin
                red = rils_pkg::DUTY_MAX; green = ramp; blue = '0;
            end
            3'd4: begin
                red = ramp_inv; green = rils_pkg::DUTY_MAX; blue = '0;
            end
            default: begin
                red = '0; green = rils_pkg::DUTY_MAX; blue = ramp;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < rils_pkg::MASK_W; i++) begin
            mask[i] = (i < rils_pkg::NUM_LEDS)
                   && (rils_pkg::LED_W'(i) != i_upd.slot)
                   && (rils_pkg::LED_W'(i) != i_upd.anim);
        end
    end

    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_upd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_upd_valid) begin
            o_out.anim_index <= i_upd.anim;
            o_out.red_duty   <= red;
            o_out.green_duty <= green;
            o_out.blue_duty  <= blue;
            o_out.slot_index <= i_upd.slot;
            o_out.slot_rgb   <= i_upd.rgb;
            o_out.off_mask   <= mask;
        end
    end

    assign o_out.valid = r_valid;

endmodule

### sv/rainbow_idle_led_stepper.sv
// rainbow idle led stepper
// i_in carries one time tick per transaction, with the selected slot led and
// its colour code. every update_period ticks the block emits one transaction
// on o_out: the animated led index, inverted pwm duties for red, green and
// blue (0 full on, 1000 off), the slot led, its mapped colour and the mask of
// leds to switch off. ticks that do not reach the period give no result.
// configuration is a plain write port: i_cfg_idx 0 is update_period,
// 1 is hue_step; write only while idle.
// a result passes two registers on its way to o_out: the state/update
// register, then the colour/output register.
// throughput: one tick per cycle while i_in.ready is high; the counter,
// hue and led position update in the cycle the tick is accepted.
// reset (synchronous, active low) clears the counter, hue and led position
// and restores period 50 and step 8; no result is pending afterwards.
// when the receiver stalls, the output register holds its transaction and
// the update register still takes one more; ticks are refused only once
// both registers are full.
module rainbow_idle_led_stepper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rils_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rils_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rils_in_if.sink                           i_in,
    rils_out_if.source                        o_out
);

    logic              upd_valid;
    rils_pkg::t_update upd;
    logic              take;
    logic              tick;

    assign i_in.ready = !upd_valid || take;
    assign tick       = i_in.valid && i_in.ready;

    rils_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick       (tick),
        .i_take       (take),
        .i_slot       (i_in.slot),
        .i_slot_code  (i_in.slot_code),
        .o_upd_valid  (upd_valid),
        .o_upd        (upd)
    );

    rils_color u_color (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd_valid (upd_valid),
        .i_upd       (upd),
        .o_take      (take),
        .o_out       (o_out)
    );

endmodule
